// ===== src/ucd_pkg.sv =====
// Shared types, constants and helper function of the UTF-8 stream decoder.
package ucd_pkg;

  localparam int BYTE_W   = 8;
  localparam int CP_W     = 32;
  localparam int PEND_W   = 3;
  localparam int LZ_W     = 4;
  localparam int TAIL_W   = 6;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = $clog2(Q_DEPTH + 1);

  localparam logic [BYTE_W-1:0] BYTE_ALL_ONES = 8'hFF;
  localparam logic [TAIL_W-1:0] TAIL_MASK     = 6'h3F;

  // How the back end has to expand one queued entry.
  typedef enum logic {
    KIND_SINGLE,  // one result, flagged last
    KIND_SPLIT    // partial value, then a zero code point flagged last
  } ucd_kind_t;

  typedef struct packed {
    ucd_kind_t         kind;
    logic [CP_W-1:0]   value;
  } ucd_entry_t;

  typedef struct packed {
    logic       valid;
    ucd_entry_t entry;
  } ucd_push_t;

  // Number of leading one bits of a byte, 0 to 8.
  function automatic logic [LZ_W-1:0] leading_ones(input logic [BYTE_W-1:0] b);
    logic [LZ_W-1:0] n;
    logic            run;
    n   = '0;
    run = 1'b1;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      run = run & b[i];
      if (run) begin
        n = n + 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ===== src/ucd_front.sv =====
// Front end: accepts bytes, tracks the sequence state and queues result entries.
module ucd_front import ucd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              q_not_full,
  output ucd_push_t         q_push
);

  logic [PEND_W-1:0] pending;
  logic [PEND_W-1:0] pending_next;
  logic [CP_W-1:0]   acc;
  logic [CP_W-1:0]   acc_next;
  logic [CP_W-1:0]   acc_shifted;
  logic [LZ_W-1:0]   ones;
  logic              accept;

  assign in_ready    = q_not_full;
  assign accept      = in_valid && in_ready;
  assign ones        = leading_ones(in_byte);
  assign acc_shifted = {acc[CP_W-TAIL_W-1:0], {TAIL_W{1'b0}}}
                     + {{(CP_W-TAIL_W){1'b0}}, in_byte[TAIL_W-1:0] & TAIL_MASK};

  always_comb begin
    pending_next       = pending;
    acc_next           = acc;
    q_push.valid       = 1'b0;
    q_push.entry.kind  = KIND_SINGLE;
    q_push.entry.value = acc;
    if (accept) begin
      if (pending != '0) begin
        if (in_byte == '0) begin
          // A terminator inside a sequence flushes the partial value first.
          q_push.valid      = 1'b1;
          q_push.entry.kind = KIND_SPLIT;
          pending_next      = '0;
          acc_next          = '0;
        end else begin
          acc_next     = acc_shifted;
          pending_next = pending - 1'b1;
          if (pending == PEND_W'(1)) begin
            q_push.valid       = 1'b1;
            q_push.entry.value = acc_shifted;
          end
        end
      end else begin
        acc_next = {{(CP_W-BYTE_W){1'b0}}, in_byte & (BYTE_ALL_ONES >> ones)};
        if (ones <= LZ_W'(1)) begin
          q_push.valid       = 1'b1;
          q_push.entry.value = acc_next;
        end else begin
          pending_next = PEND_W'(ones - 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      acc     <= '0;
    end else begin
      pending <= pending_next;
      acc     <= acc_next;
    end
  end

endmodule

// ===== src/ucd_fifo.sv =====
// Short queue of result entries between the front and back ends.
module ucd_fifo import ucd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ucd_push_t  push,
  input  logic       pop,
  output ucd_entry_t head,
  output logic       not_empty,
  output logic       not_full
);

  ucd_entry_t      mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;
  logic [Q_CW-1:0] count_next;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign not_full  = (count != Q_CW'(Q_DEPTH));

  always_comb begin
    count_next = count;
    if (push.valid && !pop) begin
      count_next = count + 1'b1;
    end else if (!push.valid && pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid && !pop |-> not_full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");
`endif

endmodule

// ===== src/ucd_back.sv =====
// Back end: expands queued entries into words held in the output register.
module ucd_back import ucd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  ucd_entry_t      q_head,
  input  logic            q_valid,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] code_point,
  output logic            last
);

  logic            phase;
  logic            phase_next;
  logic            out_valid_next;
  logic [CP_W-1:0] code_point_next;
  logic            last_next;
  logic            load;

  assign load = !out_valid || out_ready;

  always_comb begin
    q_pop           = 1'b0;
    phase_next      = phase;
    out_valid_next  = out_valid && !out_ready;
    code_point_next = code_point;
    last_next       = last;
    if (load) begin
      if (phase) begin
        // Second half of a split entry: the terminator itself.
        out_valid_next  = 1'b1;
        code_point_next = '0;
        last_next       = 1'b1;
        q_pop           = 1'b1;
        phase_next      = 1'b0;
      end else if (q_valid) begin
        out_valid_next  = 1'b1;
        code_point_next = q_head.value;
        if (q_head.kind == KIND_SPLIT) begin
          last_next  = 1'b0;
          phase_next = 1'b1;
        end else begin
          last_next = 1'b1;
          q_pop     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      phase     <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    code_point <= code_point_next;
    last       <= last_next;
  end

`ifndef NO_ASSERTIONS
  a_phase_has_entry: assert property (@(posedge clk) disable iff (rst)
    phase |-> q_valid)
    else $error("split entry left the queue before its second word");
`endif

endmodule

// ===== src/utf8_stream_decoder_unit.sv =====
// Top level of the streaming UTF-8 decoder: front end, entry queue and back end.
//
// Usage: bytes enter on in_valid / in_ready / in_byte, one word per byte.
// Decoded code points leave on out_valid / out_ready with code_point and last.
// A lead byte starts a sequence; continuation bytes are folded in six bits
// at a time and nothing is validated. Bytes that complete no sequence give
// no word. A zero byte inside a sequence gives two words: the partial value
// with last low, then code point zero with last high. Every other result is
// a single word with last high.
// The word that an accepted byte completes is first written into the queue
// and then loaded into the output register.
// Throughput: one byte per cycle; the front end takes a byte whenever the
// four-entry queue has room, and the back end drains one entry per cycle
// unless the receiver stalls; a split entry holds the queue head for two words.
// When the receiver stalls, the output register holds its word, the queue
// fills, and in_ready drops only once all four entries are occupied.
// Reset (rst, synchronous) clears the sequence state, the queue and the
// output valid flag; no word is pending afterwards.
module utf8_stream_decoder_unit import ucd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CP_W-1:0]   code_point,
  output logic              last
);

  ucd_push_t  q_push;
  ucd_entry_t q_head;
  logic       q_not_empty;
  logic       q_not_full;
  logic       q_pop;

  // Sequence tracking and classification of each accepted byte.
  ucd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .q_not_full (q_not_full),
    .q_push     (q_push)
  );

  // Decouples the byte side from the code point side.
  ucd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  // Output sequencing and the registered result port.
  ucd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_head     (q_head),
    .q_valid    (q_not_empty),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .last       (last)
  );

`ifndef NO_ASSERTIONS
  // A word without last is always the flushed half of a terminator; the
  // terminator's zero word follows right behind it.
  a_split_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && last && (code_point == '0))
    else $error("split result not followed by terminator word");
`endif

endmodule
